/* sv/lfci_pkg.sv */
package lfci_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int LOG_N       = 64;
    localparam int PTR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int FREQ_W      = 24;
    localparam int DB_W        = 16;
    localparam int ACT_W       = 2;
    localparam int ST_W        = 2;
    localparam int LOG_BITS    = $clog2(LOG_N);
    localparam int TIDX_W      = $clog2(LOG_N + 1);
    localparam int TAB_W       = 17;
    localparam int MANT_W      = FREQ_W - 1;
    localparam int EXP_W       = 5;
    localparam int LOGV_W      = 21;
    localparam int PROD_W      = TAB_W + MANT_W;
    localparam int MAG_W       = DB_W;
    localparam int DIVS_W      = LOGV_W;
    localparam int DIVD_W      = MAG_W + LOGV_W + 1;
    localparam int DIVC_W      = $clog2(DIVD_W);
    localparam int QUO_W       = DB_W + 1;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int ENTRY_W     = FREQ_W + DB_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_REJECT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FULL,
        RES_REJECT,
        RES_EMPTY,
        RES_RD_GAIN,
        RES_LOW_GAIN,
        RES_INTERP
    } t_res;

    typedef enum logic [2:0] {
        RD_FIRST,
        RD_LAST,
        RD_MID,
        RD_LOWER,
        RD_UPPER
    } t_rd_sel;

    typedef enum logic [1:0] {
        LOG_LOW,
        LOG_HIGH,
        LOG_QUERY
    } t_log_sel;

    typedef struct packed {
        logic     load;
        logic     clear_cnt;
        logic     append;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     bs_init;
        logic     bs_step;
        logic     cap_low;
        logic     cap_high;
        logic     log_start;
        logic     log_cap;
        t_log_sel log_sel;
        logic     span_calc;
        logic     mul;
        logic     div_start;
        logic     res_load;
        t_res     res_sel;
        logic     push;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    count_zero;
        logic    full;
        logic    freq_zero;
        logic    not_asc;
        logic    le_rd;
        logic    ge_rd;
        logic    bs_lt;
        logic    span_nonpos;
        logic    log_done;
        logic    div_done;
        logic    out_free;
    } t_stat;

    typedef logic [TAB_W-1:0] t_log_tab [0:LOG_N];

    // Table of floor(log2(1 + k/N) * 2^16), built bit by bit by repeated squaring.
    function automatic t_log_tab f_log_tab();
        t_log_tab   t;
        logic [63:0] x;
        logic [TAB_W-1:0] acc;
        for (int k = 0; k < LOG_N; k++) begin
            x   = (64'(LOG_N + k) << 30) / 64'(LOG_N);
            acc = '0;
            for (int b = 15; b >= 0; b--) begin
                x = (x * x) >> 30;
                if (x >= 64'h8000_0000) begin
                    x = x >> 1;
                    acc[b] = 1'b1;
                end
            end
            t[k] = acc;
        end
        t[LOG_N] = TAB_W'(65536);
        return t;
    endfunction

    localparam t_log_tab LOG_TAB = f_log_tab();

endpackage

/* sv/log_freq_calibration_interp_unit.sv */
// Microphone calibration table with log-frequency gain interpolation.
// Requests enter on the s_axis channel: tuser carries the action (clear,
// append a point, query), tdata carries frequency, point gain and measured
// magnitude. Every request produces exactly one response on m_axis: tdata
// holds the gain and the corrected magnitude, tuser holds the status code.
// The block works on one request at a time; s_axis_tready is high only while
// it is idle. Clear, append and queries that fall outside the table reach
// the response register without a search. An interpolated
// query runs a binary search through the point memory (up to 8 steps for
// 256 points), three table-based log2 evaluations and a 38-bit restoring
// division. s_axis_tready is high again in the cycle after the response
// is loaded into the output register.
// The point memory has a single registered read port, which sets the pace of
// the search. After synchronous reset (i_rst_n low) the table is empty and
// no response is pending. The response register lets the next request be
// accepted while a response still waits; if m_axis_tready stays low, the
// following response is held and no further request is taken.
module log_freq_calibration_interp_unit
    import lfci_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [23:0] freq_q, [39:24] gain_in, [55:40] magnitude_in
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] gain_out, [31:16] corrected_out
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [ST_W-1:0]        m_axis_tuser
);

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences each request; the datapath holds the point
    // memory, the log2 unit, the divider and the response register.
    lfci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lfci_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

`ifndef NO_ASSERTIONS
    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // A point is never written into a full table.
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.append |-> !stat.full)
        else $error("append issued on a full table");

    // A response is only loaded when the response register can take it.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> stat.out_free)
        else $error("response overwritten before it was taken");
`endif

endmodule

/* sv/lfci_log.sv */
module lfci_log
    import lfci_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FREQ_W-1:0] i_f,
    output logic              o_done,
    output logic [LOGV_W-1:0] o_l
);

    localparam logic [2:0] STEP_SH16 = 3'd0;
    localparam logic [2:0] STEP_SH8  = 3'd1;
    localparam logic [2:0] STEP_SH4  = 3'd2;
    localparam logic [2:0] STEP_SH2  = 3'd3;
    localparam logic [2:0] STEP_SH1  = 3'd4;
    localparam logic [2:0] STEP_LUT  = 3'd5;
    localparam logic [2:0] STEP_SUM  = 3'd6;

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_step;
    logic [FREQ_W-1:0] r_m;
    logic [EXP_W-1:0]  r_e;
    logic              r_zero;
    logic [PROD_W-1:0] r_prod;
    logic [LOGV_W-1:0] r_base;
    logic [LOGV_W-1:0] r_l;

    logic [TIDX_W-1:0] s_idx;
    logic [TAB_W-1:0]  t_lo;
    logic [TAB_W-1:0]  t_hi;
    logic [MANT_W-1:0] frac;

    always_comb begin
        s_idx = TIDX_W'(r_m[MANT_W-1 -: LOG_BITS]);
        t_lo  = LOG_TAB[s_idx];
        t_hi  = LOG_TAB[s_idx + TIDX_W'(1)];
        frac  = {r_m[MANT_W-1-LOG_BITS:0], LOG_BITS'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_SH16;
                r_m    <= i_f;
                r_e    <= EXP_W'(FREQ_W - 1);
                r_zero <= (i_f == '0);
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    STEP_SH16: begin
                        if (r_m[23:8] == '0) begin
                            r_m <= r_m << 16;
                            r_e <= r_e - EXP_W'(16);
                        end
                    end
                    STEP_SH8: begin
                        if (r_m[23:16] == '0) begin
                            r_m <= r_m << 8;
                            r_e <= r_e - EXP_W'(8);
                        end
                    end
                    STEP_SH4: begin
                        if (r_m[23:20] == '0) begin
                            r_m <= r_m << 4;
                            r_e <= r_e - EXP_W'(4);
                        end
                    end
                    STEP_SH2: begin
                        if (r_m[23:22] == '0) begin
                            r_m <= r_m << 2;
                            r_e <= r_e - EXP_W'(2);
                        end
                    end
                    STEP_SH1: begin
                        if (!r_m[23]) begin
                            r_m <= r_m << 1;
                            r_e <= r_e - EXP_W'(1);
                        end
                    end
                    STEP_LUT: begin
                        r_prod <= PROD_W'(t_hi - t_lo) * PROD_W'(frac);
                        r_base <= {r_e, 16'b0} + LOGV_W'(t_lo);
                    end
                    STEP_SUM: begin
                        r_l    <= r_zero ? '0 : r_base + LOGV_W'(r_prod[PROD_W-1:MANT_W]);
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_l    = r_l;

endmodule

/* sv/lfci_div.sv */
module lfci_div
    import lfci_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [DIVC_W-1:0] r_cnt;
    logic [DIVS_W:0]   r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   rem_sh;
    logic              fits;

    always_comb begin
        rem_sh = {r_rem[DIVS_W-1:0], r_quo[DIVD_W-1]};
        fits   = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sh - {1'b0, r_dvs} : rem_sh;
                r_quo <= {r_quo[DIVD_W-2:0], fits};
                r_cnt <= r_cnt + DIVC_W'(1);
                if (r_cnt == DIVC_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[QUO_W-1:0];

endmodule

/* sv/lfci_dp.sv */
module lfci_dp
    import lfci_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic [ACT_W-1:0]       i_in_user,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic [ST_W-1:0]        o_out_user
);

    logic [ENTRY_W-1:0] mem [0:MAX_POINTS-1];

    logic [ACT_W-1:0]   r_action;
    logic [FREQ_W-1:0]  r_freq;
    logic [DB_W-1:0]    r_gain_in;
    logic [DB_W-1:0]    r_mag;
    logic [CNT_W-1:0]   r_count;
    logic [FREQ_W-1:0]  r_last_freq;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [PTR_W-1:0]   r_lo;
    logic [PTR_W-1:0]   r_hi;
    logic [DB_W-1:0]    r_gl;
    logic [DB_W-1:0]    r_gh;
    logic [LOGV_W-1:0]  r_ll;
    logic [LOGV_W-1:0]  r_lh;
    logic [LOGV_W-1:0]  r_lf;
    logic [LOGV_W:0]    r_span;
    logic [LOGV_W-1:0]  r_num;
    logic               r_neg;
    logic [MAG_W-1:0]   r_dmag;
    logic [DIVD_W-1:0]  r_prod;
    logic [DB_W-1:0]    r_res_gain;
    logic [DB_W-1:0]    r_res_corr;
    logic [ST_W-1:0]    r_res_st;
    logic               r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [ST_W-1:0]    r_out_user;

    logic [FREQ_W-1:0]  rd_freq;
    logic [DB_W-1:0]    rd_gain;
    logic [PTR_W-1:0]   mid;
    logic [PTR_W-1:0]   rd_addr;
    logic               log_done;
    logic [LOGV_W-1:0]  log_l;
    logic [FREQ_W-1:0]  log_f;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [LOGV_W:0]    span_c;
    logic [LOGV_W:0]    num_c;
    logic [DB_W:0]      d_c;
    logic [DB_W:0]      q_s;
    logic [DB_W:0]      interp;
    logic [DB_W-1:0]    res_gain;
    logic [DB_W-1:0]    res_corr;
    logic [ST_W-1:0]    res_st;
    logic [DB_W:0]      diff;
    logic               out_free;

    assign rd_freq  = r_rd_data[FREQ_W-1:0];
    assign rd_gain  = r_rd_data[ENTRY_W-1:FREQ_W];
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_LAST:  rd_addr = PTR_W'(r_count - CNT_W'(1));
            RD_MID:   rd_addr = mid;
            RD_LOWER: rd_addr = r_lo - PTR_W'(1);
            RD_UPPER: rd_addr = r_lo;
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem[PTR_W'(r_count)] <= {r_gain_in, r_freq};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.log_sel)
            LOG_LOW:   log_f = rd_freq;
            LOG_HIGH:  log_f = rd_freq;
            LOG_QUERY: log_f = r_freq;
            default:   log_f = r_freq;
        endcase
    end

    lfci_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.log_start),
        .i_f     (log_f),
        .o_done  (log_done),
        .o_l     (log_l)
    );

    lfci_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod + DIVD_W'(r_span[LOGV_W-1:1])),
        .i_divisor  (r_span[DIVS_W-1:0]),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // The low log is held in r_ll until the high point's log is ready. The lower
    // point's frequency stays in the read register through the low log only.
    always_comb begin
        span_c = {1'b0, r_lh} - {1'b0, r_ll};
        num_c  = {1'b0, r_lf} - {1'b0, r_ll};
        d_c    = {r_gh[DB_W-1], r_gh} - {r_gl[DB_W-1], r_gl};
        q_s    = r_neg ? -{1'b0, div_quo[DB_W-1:0]} : {1'b0, div_quo[DB_W-1:0]};
        interp = {r_gl[DB_W-1], r_gl} + q_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_in_user;
            r_freq    <= i_in_data[FREQ_W-1:0];
            r_gain_in <= i_in_data[FREQ_W+DB_W-1:FREQ_W];
            r_mag     <= i_in_data[FREQ_W+2*DB_W-1:FREQ_W+DB_W];
        end
        if (i_cmd.append) begin
            r_last_freq <= r_freq;
        end
        if (i_cmd.bs_init) begin
            r_lo <= '0;
            r_hi <= PTR_W'(r_count - CNT_W'(1));
        end else if (i_cmd.bs_step) begin
            if (rd_freq < r_freq) begin
                r_lo <= mid + PTR_W'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.cap_low) begin
            r_gl <= rd_gain;
        end
        if (i_cmd.cap_high) begin
            r_gh <= rd_gain;
        end
        if (i_cmd.log_cap) begin
            case (i_cmd.log_sel)
                LOG_LOW:   r_ll <= log_l;
                LOG_HIGH:  r_lh <= log_l;
                LOG_QUERY: r_lf <= log_l;
                default:   r_lf <= log_l;
            endcase
        end
        if (i_cmd.span_calc) begin
            r_span <= span_c;
            if (num_c[LOGV_W]) begin
                r_num <= '0;
            end else if (num_c > span_c) begin
                r_num <= span_c[LOGV_W-1:0];
            end else begin
                r_num <= num_c[LOGV_W-1:0];
            end
            r_neg  <= d_c[DB_W];
            r_dmag <= d_c[DB_W] ? MAG_W'(-d_c) : d_c[MAG_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= DIVD_W'(r_dmag) * DIVD_W'(r_num);
        end
    end

    always_comb begin
        res_gain = '0;
        res_st   = ST_OK;
        case (i_cmd.res_sel)
            RES_ZERO:     res_st = ST_OK;
            RES_FULL:     res_st = ST_FULL;
            RES_REJECT:   res_st = ST_REJECT;
            RES_EMPTY:    res_st = ST_EMPTY;
            RES_RD_GAIN:  res_gain = rd_gain;
            RES_LOW_GAIN: res_gain = r_gl;
            RES_INTERP:   res_gain = interp[DB_W-1:0];
            default:      res_st = ST_OK;
        endcase
        diff = {r_mag[DB_W-1], r_mag} - {res_gain[DB_W-1], res_gain};
        if (diff[DB_W] != diff[DB_W-1]) begin
            res_corr = diff[DB_W] ? {1'b1, {(DB_W-1){1'b0}}} : {1'b0, {(DB_W-1){1'b1}}};
        end else begin
            res_corr = diff[DB_W-1:0];
        end
        case (i_cmd.res_sel)
            RES_ZERO, RES_FULL, RES_REJECT: res_corr = '0;
            RES_EMPTY:                      res_corr = r_mag;
            default:                        ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_gain <= res_gain;
            r_res_corr <= res_corr;
            r_res_st   <= res_st;
        end
        if (i_cmd.push) begin
            r_out_data <= {r_res_corr, r_res_gain};
            r_out_user <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_cnt) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.action      = t_action'(r_action);
        o_stat.count_zero  = (r_count == '0);
        o_stat.full        = (r_count >= CNT_W'(MAX_POINTS));
        o_stat.freq_zero   = (r_freq == '0);
        o_stat.not_asc     = (r_count != '0) && (r_freq <= r_last_freq);
        o_stat.le_rd       = (r_freq <= rd_freq);
        o_stat.ge_rd       = (r_freq >= rd_freq);
        o_stat.bs_lt       = (r_lo < r_hi);
        o_stat.span_nonpos = r_span[LOGV_W] || (r_span == '0);
        o_stat.log_done    = log_done;
        o_stat.div_done    = div_done;
        o_stat.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

/* sv/lfci_ctrl.sv */
module lfci_ctrl
    import lfci_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_DECODE    = 15'b000000000000010,
        S_Q_CHK0    = 15'b000000000000100,
        S_Q_CHKN    = 15'b000000000001000,
        S_BS_RD     = 15'b000000000010000,
        S_BS_CMP    = 15'b000000000100000,
        S_RD_UPPER  = 15'b000000001000000,
        S_CAP_UPPER = 15'b000000010000000,
        S_LOG_LOW   = 15'b000000100000000,
        S_LOG_HIGH  = 15'b000001000000000,
        S_LOG_QUERY = 15'b000010000000000,
        S_SPAN      = 15'b000100000000000,
        S_MUL       = 15'b001000000000000,
        S_DIV       = 15'b010000000000000,
        S_OUT       = 15'b100000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_div_go;
    logic   n_div_go;

    always_comb begin
        n_state    = r_state;
        n_div_go   = 1'b0;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.res_sel = RES_ZERO;
                n_state       = S_OUT;
                case (i_stat.action)
                    ACT_CLEAR: begin
                        o_cmd.clear_cnt = 1'b1;
                        o_cmd.res_load  = 1'b1;
                    end
                    ACT_APPEND: begin
                        o_cmd.res_load = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.res_sel = RES_FULL;
                        end else if (i_stat.freq_zero || i_stat.not_asc) begin
                            o_cmd.res_sel = RES_REJECT;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end
                    ACT_QUERY: begin
                        if (i_stat.count_zero) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_EMPTY;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_FIRST;
                            n_state      = S_Q_CHK0;
                        end
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                    end
                endcase
            end
            S_Q_CHK0: begin
                if (i_stat.le_rd) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_RD_GAIN;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                    n_state      = S_Q_CHKN;
                end
            end
            S_Q_CHKN: begin
                if (i_stat.ge_rd) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_RD_GAIN;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.bs_init = 1'b1;
                    n_state       = S_BS_RD;
                end
            end
            S_BS_RD: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.bs_lt) begin
                    o_cmd.rd_sel = RD_MID;
                    n_state      = S_BS_CMP;
                end else begin
                    o_cmd.rd_sel = RD_LOWER;
                    n_state      = S_RD_UPPER;
                end
            end
            S_BS_CMP: begin
                o_cmd.bs_step = 1'b1;
                n_state       = S_BS_RD;
            end
            S_RD_UPPER: begin
                o_cmd.cap_low   = 1'b1;
                o_cmd.log_start = 1'b1;
                o_cmd.log_sel   = LOG_LOW;
                n_state         = S_LOG_LOW;
            end
            S_LOG_LOW: begin
                o_cmd.log_sel = LOG_LOW;
                if (i_stat.log_done) begin
                    o_cmd.log_cap = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RD_UPPER;
                    n_state       = S_CAP_UPPER;
                end
            end
            S_CAP_UPPER: begin
                o_cmd.cap_high  = 1'b1;
                o_cmd.log_start = 1'b1;
                o_cmd.log_sel   = LOG_HIGH;
                n_state         = S_LOG_HIGH;
            end
            S_LOG_HIGH: begin
                o_cmd.log_sel = LOG_HIGH;
                if (i_stat.log_done) begin
                    o_cmd.log_cap = 1'b1;
                    n_state       = S_LOG_QUERY;
                    n_div_go      = 1'b1;
                end
            end
            S_LOG_QUERY: begin
                o_cmd.log_sel = LOG_QUERY;
                if (r_div_go) begin
                    o_cmd.log_start = 1'b1;
                end else if (i_stat.log_done) begin
                    o_cmd.log_cap = 1'b1;
                    n_state       = S_SPAN;
                end
            end
            S_SPAN: begin
                o_cmd.span_calc = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                if (i_stat.span_nonpos) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_LOW_GAIN;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV;
                    n_div_go  = 1'b1;
                end
            end
            S_DIV: begin
                if (r_div_go) begin
                    o_cmd.div_start = 1'b1;
                end else if (i_stat.div_done) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_INTERP;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= n_div_go;
        end
    end

endmodule
